// ----- design/prg_pkg.sv -----
package prg_pkg;

    localparam int COORD_BITS = 12;
    localparam int PIX_W      = 12;
    localparam logic [PIX_W-1:0] COORD_MASK = PIX_W'((64'd1 << COORD_BITS) - 64'd1);

    // Square root retires one result bit per stage; division one quotient bit.
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 15;
    localparam logic [DIV_STEPS-1:0] DIR_ONE = DIV_STEPS'(16384);

    typedef enum logic [2:0] {
        REG_PIXEL_PITCH,
        REG_HALF_EXTENTS,
        REG_INV_ROW_X,
        REG_INV_ROW_Y,
        REG_INV_ROW_Z,
        REG_EYE_X,
        REG_EYE_Y,
        REG_EYE_Z
    } reg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0]   out_pixel_x;
        logic [PIX_W-1:0]   out_pixel_y;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } ray_t;

    // Per-ray data that rides alongside the square root and the divider.
    typedef struct packed {
        logic             zero;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic [2:0]       neg;
        logic [2:0][30:0] mag;
    } side_t;

endpackage

// ----- design/prg_isqrt.sv -----
module prg_isqrt (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  prg_pkg::side_t  in_side,
    input  logic [63:0]     in_sum,
    output logic            out_valid,
    output prg_pkg::side_t  out_side,
    output logic [31:0]     out_root
);

    logic           vld_reg  [prg_pkg::SQ_STEPS];
    prg_pkg::side_t side_reg [prg_pkg::SQ_STEPS];
    logic [63:0]    s_reg    [prg_pkg::SQ_STEPS];
    logic [63:0]    res_reg  [prg_pkg::SQ_STEPS];

    logic           vld_in   [prg_pkg::SQ_STEPS];
    prg_pkg::side_t side_in  [prg_pkg::SQ_STEPS];
    logic [63:0]    s_in     [prg_pkg::SQ_STEPS];
    logic [63:0]    res_in   [prg_pkg::SQ_STEPS];
    logic [63:0]    s_next   [prg_pkg::SQ_STEPS];
    logic [63:0]    res_next [prg_pkg::SQ_STEPS];

    always_comb
    begin
        vld_in[0]  = in_valid;
        side_in[0] = in_side;
        s_in[0]    = in_sum;
        res_in[0]  = '0;
        for (int k = 1; k < prg_pkg::SQ_STEPS; k++)
        begin
            vld_in[k]  = vld_reg[k-1];
            side_in[k] = side_reg[k-1];
            s_in[k]    = s_reg[k-1];
            res_in[k]  = res_reg[k-1];
        end
    end

    // Classic digit-by-digit square root: stage k tests the bit worth 4^(31-k).
    always_comb
    begin
        logic [63:0] bit_k;
        logic [63:0] trial;
        for (int k = 0; k < prg_pkg::SQ_STEPS; k++)
        begin
            bit_k = 64'd1 << (6'(62 - 2 * k));
            trial = res_in[k] + bit_k;
            if (s_in[k] >= trial)
            begin
                s_next[k]   = s_in[k] - trial;
                res_next[k] = (res_in[k] >> 1) + bit_k;
            end
            else
            begin
                s_next[k]   = s_in[k];
                res_next[k] = res_in[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < prg_pkg::SQ_STEPS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < prg_pkg::SQ_STEPS; k++)
            begin
                vld_reg[k] <= vld_in[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < prg_pkg::SQ_STEPS; k++)
        begin
            side_reg[k] <= side_in[k];
            s_reg[k]    <= s_next[k];
            res_reg[k]  <= res_next[k];
        end
    end

    assign out_valid = vld_reg[prg_pkg::SQ_STEPS-1];
    assign out_side  = side_reg[prg_pkg::SQ_STEPS-1];
    assign out_root  = res_reg[prg_pkg::SQ_STEPS-1][31:0];

endmodule

// ----- design/prg_div.sv -----
module prg_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  prg_pkg::side_t                     in_side,
    input  logic [31:0]                        in_root,
    output logic                               out_valid,
    output prg_pkg::side_t                     out_side,
    output logic [2:0][prg_pkg::DIV_STEPS-1:0] out_quot
);

    localparam int NS = prg_pkg::DIV_STEPS + 1;

    logic                               vld_reg  [NS];
    prg_pkg::side_t                     side_reg [NS];
    logic [31:0]                        den_reg  [NS];
    logic [2:0][45:0]                   num_reg  [NS];
    logic [2:0][31:0]                   rem_reg  [NS];
    logic [2:0][prg_pkg::DIV_STEPS-1:0] q_reg    [NS];

    logic [2:0][45:0]                   num0;
    logic [2:0][31:0]                   rem0;
    logic [2:0][31:0]                   rem_next [prg_pkg::DIV_STEPS];
    logic [2:0][prg_pkg::DIV_STEPS-1:0] q_next   [prg_pkg::DIV_STEPS];

    // Numerator is the magnitude in Q14 plus half the norm, for rounding to nearest.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num0[i] = {1'b0, in_side.mag[i], 14'd0} + 46'(in_root >> 1);
            rem0[i] = 32'(num0[i] >> prg_pkg::DIV_STEPS);
        end
    end

    // The quotient never exceeds 2^14, so the top remainder already sits below the norm.
    always_comb
    begin
        logic [32:0] trial;
        for (int k = 0; k < prg_pkg::DIV_STEPS; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                trial = {rem_reg[k][i], num_reg[k][i][prg_pkg::DIV_STEPS-1-k]};
                if (trial >= {1'b0, den_reg[k]})
                begin
                    rem_next[k][i] = 32'(trial - {1'b0, den_reg[k]});
                    q_next[k][i]   = {q_reg[k][i][prg_pkg::DIV_STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][i] = trial[31:0];
                    q_next[k][i]   = {q_reg[k][i][prg_pkg::DIV_STEPS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        den_reg[0]  <= in_root;
        num_reg[0]  <= num0;
        rem_reg[0]  <= rem0;
        q_reg[0]    <= '0;
        for (int k = 1; k < NS; k++)
        begin
            side_reg[k] <= side_reg[k-1];
            den_reg[k]  <= den_reg[k-1];
            num_reg[k]  <= num_reg[k-1];
            rem_reg[k]  <= rem_next[k-1];
            q_reg[k]    <= q_next[k-1];
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign out_quot  = q_reg[NS-1];

endmodule

// ----- design/primary_ray_generator.sv -----
// Channel  | Ports                            | Beat
// ---------+----------------------------------+-------------------------------------
// pixel in | start, busy, pixel               | edge with start high and busy low
// ray out  | done, result                     | the one cycle done is high
// config   | wr_en, wr_index, wr_data         | edge with wr_en high
//
// One pixel may be taken every cycle; busy stays low.
// A ray passes through 10 arithmetic stages, 32 square root stages (one root
// bit each), 16 divider stages (a load, then one quotient bit each) and one
// output stage.
// Reset empties the pipeline and loads the identity transform; nothing is cleared by a sweep.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module primary_ray_generator (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  prg_pkg::pixel_t pixel,
    output logic            done,
    output prg_pkg::ray_t   result,
    input  logic            wr_en,
    input  logic [2:0]      wr_index,
    input  logic [63:0]     wr_data
);

    localparam int PW = prg_pkg::PIX_W;

    logic [31:0] pitch_reg;
    logic [63:0] half_reg;
    logic [47:0] row_reg [3];
    logic [31:0] eye_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg  <= '0;
            half_reg   <= '0;
            row_reg[0] <= 48'h4000_0000_0000;
            row_reg[1] <= 48'h0000_4000_0000;
            row_reg[2] <= 48'h0000_0000_4000;
            eye_reg[0] <= '0;
            eye_reg[1] <= '0;
            eye_reg[2] <= '0;
        end
        else if (wr_en)
        begin
            unique case (prg_pkg::reg_idx_t'(wr_index))
                prg_pkg::REG_PIXEL_PITCH:  pitch_reg  <= wr_data[31:0];
                prg_pkg::REG_HALF_EXTENTS: half_reg   <= wr_data;
                prg_pkg::REG_INV_ROW_X:    row_reg[0] <= wr_data[47:0];
                prg_pkg::REG_INV_ROW_Y:    row_reg[1] <= wr_data[47:0];
                prg_pkg::REG_INV_ROW_Z:    row_reg[2] <= wr_data[47:0];
                prg_pkg::REG_EYE_X:        eye_reg[0] <= wr_data[31:0];
                prg_pkg::REG_EYE_Y:        eye_reg[1] <= wr_data[31:0];
                prg_pkg::REG_EYE_Z:        eye_reg[2] <= wr_data[31:0];
            endcase
        end
    end

    logic signed [15:0] m [3][3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                m[r][c] = row_reg[r][47 - 16 * c -: 16];
            end
        end
    end

    assign busy = 1'b0;

    // Valid bits and pixel tags of the ten arithmetic stages.
    logic            vld_reg [1:10];
    prg_pkg::pixel_t tag_reg [1:10];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= 10; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[1] <= start & ~busy;
            for (int s = 2; s <= 10; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // Stage 1: pixel centre offset, ((2p + 1) * pitch + 2^12) >> 13.
    logic [PW-1:0] px_m, py_m;
    logic [45:0]   ox_full, oy_full;
    logic [31:0]   offx1_reg, offy1_reg;

    assign px_m    = pixel.pixel_x & prg_pkg::COORD_MASK;
    assign py_m    = pixel.pixel_y & prg_pkg::COORD_MASK;
    assign ox_full = 46'({px_m, 1'b1}) * 46'(pitch_reg) + 46'd4096;
    assign oy_full = 46'({py_m, 1'b1}) * 46'(pitch_reg) + 46'd4096;

    // Stage 2: view plane point.
    logic signed [33:0] wx2_reg, wy2_reg;

    // Stage 3: matrix products, stage 4: row sums.
    logic signed [49:0] pa3_reg [3];
    logic signed [49:0] pb3_reg [3];
    logic signed [50:0] v4_reg  [3];

    // Stages 5 to 8: magnitudes, their maximum, its leading one, the common shift.
    logic [2:0]   neg_reg [5:10];
    logic [49:0]  mag5_reg [3];
    logic [49:0]  mag6_reg [3];
    logic [49:0]  max6_reg;
    logic [49:0]  mag7_reg [3];
    logic [5:0]   pos7_reg;
    logic         zero_reg [7:10];
    logic [2:0][30:0] mag8_reg, mag9_reg, mag10_reg;

    // Stages 9 and 10: squares and their sum.
    logic [61:0] sq9_reg [3];
    logic [63:0] sum10_reg;

    logic [49:0] max_c;
    logic [5:0]  pos_c;
    logic [2:0][30:0] mag_sh;

    always_comb
    begin
        max_c = mag5_reg[0];
        if (mag5_reg[1] > max_c)
        begin
            max_c = mag5_reg[1];
        end
        if (mag5_reg[2] > max_c)
        begin
            max_c = mag5_reg[2];
        end
    end

    always_comb
    begin
        pos_c = '0;
        for (int i = 0; i < 50; i++)
        begin
            if (max6_reg[i])
            begin
                pos_c = 6'(i);
            end
        end
    end

    // A right shift truncates; a left shift never overflows since no value exceeds the max.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            if (pos7_reg >= 6'd31)
            begin
                mag_sh[r] = 31'(mag7_reg[r] >> (pos7_reg - 6'd30));
            end
            else
            begin
                mag_sh[r] = 31'(mag7_reg[r] << (6'd30 - pos7_reg));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[1] <= '{pixel_x: px_m, pixel_y: py_m};
        for (int s = 2; s <= 10; s++)
        begin
            tag_reg[s] <= tag_reg[s-1];
        end
        offx1_reg <= ox_full[44:13];
        offy1_reg <= oy_full[44:13];
        wx2_reg   <= $signed({2'b00, half_reg[63:32]}) - $signed({2'b00, offx1_reg});
        wy2_reg   <= $signed({2'b00, half_reg[31:0]}) - $signed({2'b00, offy1_reg});
        for (int r = 0; r < 3; r++)
        begin
            pa3_reg[r]  <= m[r][0] * wx2_reg;
            pb3_reg[r]  <= m[r][1] * wy2_reg;
            v4_reg[r]   <= 51'(pa3_reg[r]) + 51'(pb3_reg[r]) - (51'(m[r][2]) <<< 16);
            neg_reg[5][r] <= v4_reg[r][50];
            mag5_reg[r] <= v4_reg[r][50] ? 50'(-v4_reg[r]) : v4_reg[r][49:0];
            mag6_reg[r] <= mag5_reg[r];
            mag7_reg[r] <= mag6_reg[r];
            sq9_reg[r]  <= 62'(mag8_reg[r]) * 62'(mag8_reg[r]);
        end
        for (int s = 6; s <= 10; s++)
        begin
            neg_reg[s] <= neg_reg[s-1];
        end
        max6_reg  <= max_c;
        pos7_reg  <= pos_c;
        zero_reg[7] <= (max6_reg == '0);
        for (int s = 8; s <= 10; s++)
        begin
            zero_reg[s] <= zero_reg[s-1];
        end
        mag8_reg  <= mag_sh;
        mag9_reg  <= mag8_reg;
        mag10_reg <= mag9_reg;
        sum10_reg <= 64'(sq9_reg[0]) + 64'(sq9_reg[1]) + 64'(sq9_reg[2]);
    end

    prg_pkg::side_t side10;
    logic           sq_vld;
    prg_pkg::side_t sq_side;
    logic [31:0]    sq_root;
    logic           dv_vld;
    prg_pkg::side_t dv_side;
    logic [2:0][prg_pkg::DIV_STEPS-1:0] dv_quot;

    assign side10 = '{zero: zero_reg[10], px: tag_reg[10].pixel_x, py: tag_reg[10].pixel_y,
                      neg: neg_reg[10], mag: mag10_reg};

    prg_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[10]),
        .in_side   (side10),
        .in_sum    (sum10_reg),
        .out_valid (sq_vld),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    prg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_vld),
        .in_side   (sq_side),
        .in_root   (sq_root),
        .out_valid (dv_vld),
        .out_side  (dv_side),
        .out_quot  (dv_quot)
    );

    // Output stage: saturate to one, restore the sign, zero for a degenerate direction.
    logic               done_reg;
    prg_pkg::ray_t      result_reg;
    logic signed [15:0] dir_c [3];

    always_comb
    begin
        logic [15:0] d;
        for (int r = 0; r < 3; r++)
        begin
            d = (dv_quot[r] > prg_pkg::DIR_ONE) ? 16'(prg_pkg::DIR_ONE) : 16'(dv_quot[r]);
            if (dv_side.zero)
            begin
                dir_c[r] = '0;
            end
            else if (dv_side.neg[r])
            begin
                dir_c[r] = -$signed(d);
            end
            else
            begin
                dir_c[r] = $signed(d);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.out_pixel_x <= dv_side.px;
        result_reg.out_pixel_y <= dv_side.py;
        result_reg.origin_x    <= $signed(eye_reg[0]);
        result_reg.origin_y    <= $signed(eye_reg[1]);
        result_reg.origin_z    <= $signed(eye_reg[2]);
        result_reg.dir_x       <= dir_c[0];
        result_reg.dir_y       <= dir_c[1];
        result_reg.dir_z       <= dir_c[2];
    end

    assign done   = done_reg;
    assign result = result_reg;

    ap_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[8] && !zero_reg[8] |-> (mag8_reg[0][30] || mag8_reg[1][30] || mag8_reg[2][30]))
        else $error("normalized maximum outside [2^30, 2^31)");

    ap_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld && !sq_side.zero |-> sq_root[31:30] != 2'b00)
        else $error("norm below 2^30 for a nonzero direction");

    ap_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld && !dv_side.zero |-> (dv_quot[0] <= prg_pkg::DIR_ONE)
            && (dv_quot[1] <= prg_pkg::DIR_ONE) && (dv_quot[2] <= prg_pkg::DIR_ONE))
        else $error("direction component exceeds one");

endmodule

// ----- tb/sv/tb.sv -----
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RAY_LATENCY = 59;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    prg_pkg::pixel_t pixel;
    logic            done;
    prg_pkg::ray_t   result;
    logic            wr_en;
    logic [2:0]      wr_index;
    logic [63:0]     wr_data;

    // Camera state mirrored from the register writes.
    logic [31:0] cam_pitch;
    logic [63:0] cam_extents;
    logic [47:0] cam_row [3];
    logic [31:0] cam_eye [3];

    prg_pkg::pixel_t pending_pixels[$];
    prg_pkg::ray_t   rays_due[$];
    int              errors;
    int              cycles;
    bit              calm;

    primary_ray_generator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .pixel    (pixel),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint centre_offset(logic [prg_pkg::PIX_W-1:0] p);
        bit [63:0] odd;
        odd = 2 * {52'b0, p} + 1;
        return longint'((odd * {32'b0, cam_pitch} + 64'd4096) >> 13);
    endfunction

    function automatic bit [63:0] floor_sqrt(bit [63:0] s);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s)
            b >>= 2;
        while (b != 0)
        begin
            if (s >= res + b)
            begin
                s -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic prg_pkg::ray_t trace_ray(prg_pkg::pixel_t p);
        prg_pkg::ray_t r;
        longint    wx;
        longint    wy;
        longint    v [3];
        bit [63:0] mag [3];
        bit [63:0] peak;
        bit [63:0] sum;
        bit [63:0] root;
        bit [63:0] d;
        logic [prg_pkg::PIX_W-1:0] px;
        logic [prg_pkg::PIX_W-1:0] py;
        px = p.pixel_x & prg_pkg::COORD_MASK;
        py = p.pixel_y & prg_pkg::COORD_MASK;
        wx = longint'({32'b0, cam_extents[63:32]}) - centre_offset(px);
        wy = longint'({32'b0, cam_extents[31:0]}) - centre_offset(py);
        peak = 0;
        for (int i = 0; i < 3; i++)
        begin
            v[i] = longint'($signed(cam_row[i][47:32])) * wx
                 + longint'($signed(cam_row[i][31:16])) * wy
                 - longint'($signed(cam_row[i][15:0])) * 65536;
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            if (mag[i] > peak)
                peak = mag[i];
        end
        r.out_pixel_x = px;
        r.out_pixel_y = py;
        r.origin_x = cam_eye[0];
        r.origin_y = cam_eye[1];
        r.origin_z = cam_eye[2];
        r.dir_x = '0;
        r.dir_y = '0;
        r.dir_z = '0;
        if (peak == 0)
            return r;
        while (peak >= (64'd1 << 31))
        begin
            peak >>= 1;
            for (int i = 0; i < 3; i++)
                mag[i] >>= 1;
        end
        while (peak < (64'd1 << 30))
        begin
            peak <<= 1;
            for (int i = 0; i < 3; i++)
                mag[i] <<= 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++)
            sum += mag[i] * mag[i];
        root = floor_sqrt(sum);
        if (root == 0)
            root = 1;
        for (int i = 0; i < 3; i++)
        begin
            d = (mag[i] * 16384 + root / 2) / root;
            if (d > 16384)
                d = 16384;
            if (v[i] < 0)
                d = -d;
            case (i)
                0: r.dir_x = d[15:0];
                1: r.dir_y = d[15:0];
                default: r.dir_z = d[15:0];
            endcase
        end
        return r;
    endfunction

    task automatic write_reg(prg_pkg::reg_idx_t idx, logic [63:0] data);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        case (idx)
            prg_pkg::REG_PIXEL_PITCH:  cam_pitch = data[31:0];
            prg_pkg::REG_HALF_EXTENTS: cam_extents = data;
            prg_pkg::REG_INV_ROW_X:    cam_row[0] = data[47:0];
            prg_pkg::REG_INV_ROW_Y:    cam_row[1] = data[47:0];
            prg_pkg::REG_INV_ROW_Z:    cam_row[2] = data[47:0];
            prg_pkg::REG_EYE_X:        cam_eye[0] = data[31:0];
            prg_pkg::REG_EYE_Y:        cam_eye[1] = data[31:0];
            default:                   cam_eye[2] = data[31:0];
        endcase
    endtask

    task automatic setup_camera(logic [31:0] pitch, logic [63:0] ext, logic [47:0] rx,
                                logic [47:0] ry, logic [47:0] rz, logic [31:0] ex,
                                logic [31:0] ey, logic [31:0] ez);
        write_reg(prg_pkg::REG_PIXEL_PITCH, {32'b0, pitch});
        write_reg(prg_pkg::REG_HALF_EXTENTS, ext);
        write_reg(prg_pkg::REG_INV_ROW_X, {16'b0, rx});
        write_reg(prg_pkg::REG_INV_ROW_Y, {16'b0, ry});
        write_reg(prg_pkg::REG_INV_ROW_Z, {16'b0, rz});
        write_reg(prg_pkg::REG_EYE_X, {32'b0, ex});
        write_reg(prg_pkg::REG_EYE_Y, {32'b0, ey});
        write_reg(prg_pkg::REG_EYE_Z, {32'b0, ez});
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic queue_pixel(int x, int y);
        prg_pkg::pixel_t p;
        p.pixel_x = x[prg_pkg::PIX_W-1:0];
        p.pixel_y = y[prg_pkg::PIX_W-1:0];
        pending_pixels.push_back(p);
    endtask

    task automatic queue_corners();
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(0, 4095);
        queue_pixel(4095, 0);
        queue_pixel(2048, 1);
    endtask

    task automatic queue_random(int count);
        repeat (count)
            queue_pixel($urandom_range(4095), $urandom_range(4095));
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0 || rays_due.size() != 0 || start)
            @(posedge clk);
    endtask

    function automatic logic [47:0] random_row();
        logic [15:0] c [3];
        for (int i = 0; i < 3; i++)
        begin
            case ($urandom_range(3))
                0: c[i] = 16'h4000;
                1: c[i] = 16'hC000;
                2: c[i] = 16'($urandom_range(16'h8000, 16'h7FFF) ^ 16'h8000);
                default: c[i] = 16'($urandom);
            endcase
        end
        return {c[0], c[1], c[2]};
    endfunction

    // Pixel driver: a beat is taken on each edge with start high and busy low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            pixel <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                rays_due.push_back(trace_ray(pixel));
                void'(pending_pixels.pop_front());
            end
            if (!(start && busy))
            begin
                if (pending_pixels.size() != 0 && (calm || $urandom_range(99) >= 20))
                begin
                    start <= 1'b1;
                    pixel <= pending_pixels[0];
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, longint expd, longint got);
        if (expd != got)
        begin
            $error("%s: expected %0h, got %0h", name, expd, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        prg_pkg::ray_t want;
        if (rst_n && done)
        begin
            if (rays_due.size() == 0)
            begin
                $error("ray with no pixel outstanding");
                errors++;
            end
            else
            begin
                want = rays_due.pop_front();
                check_field("out_pixel_x", want.out_pixel_x, result.out_pixel_x);
                check_field("out_pixel_y", want.out_pixel_y, result.out_pixel_y);
                check_field("origin_x", want.origin_x, result.origin_x);
                check_field("origin_y", want.origin_y, result.origin_y);
                check_field("origin_z", want.origin_z, result.origin_z);
                check_field("dir_x", want.dir_x, result.dir_x);
                check_field("dir_y", want.dir_y, result.dir_y);
                check_field("dir_z", want.dir_z, result.dir_z);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        cam_pitch = '0;
        cam_extents = '0;
        cam_row[0] = 48'h4000_0000_0000;
        cam_row[1] = 48'h0000_4000_0000;
        cam_row[2] = 48'h0000_0000_4000;
        cam_eye[0] = '0;
        cam_eye[1] = '0;
        cam_eye[2] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Values left by reset: every ray points straight down the view axis.
        queue_corners();
        drain();

        // A plausible camera: 1280 pixels across a view of half width one.
        setup_camera(32'd419430, {32'h0001_0000, 32'h0000_C000}, 48'h4000_0000_0000,
                     48'h0000_4000_0000, 48'h0000_0000_4000, 32'h0003_0000,
                     32'hFFFE_8000, 32'h0000_1234);
        queue_corners();
        queue_random(100);
        drain();

        // Extremes of every register.
        setup_camera('1, '1, 48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000, 48'h7FFF_7FFF_7FFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_corners();
        drain();

        // A zero matrix gives a degenerate, all zero direction.
        setup_camera(32'h1234_5678, 64'h0000_8000_0000_4000, '0, '0, '0, '0, '0, '0);
        queue_corners();
        drain();

        // Degenerate only at the exact view centre, with no depth column.
        setup_camera(32'h0100_0000, {32'h0000_8000, 32'h0000_8000}, 48'h4000_0000_0000,
                     48'h0000_4000_0000, 48'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
        queue_pixel(0, 0);
        queue_pixel(1, 1);
        queue_pixel(0, 1);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            setup_camera($urandom >> $urandom_range(31), {$urandom, $urandom},
                         random_row(), random_row(), random_row(),
                         $urandom, $urandom, $urandom);
            calm = (ph == 3);
            queue_random(110);
            drain();
        end
        calm = 1'b0;

        repeat (RAY_LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
